// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file pitb_checker
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define PITB_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond) else $error(msg);

// checked at every edge, reset included
`define PITB_CHECK_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) cond) else $error(msg);

`endif

// ----- rtl/pitb_pkg.sv -----
// shared types and codes for the barycentric point-in-triangle core
// no dependencies
`timescale 1ns / 1ps

package pitb_pkg;

    typedef enum logic [2:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_B_X = 3'd2,
        REG_B_Y = 3'd3,
        REG_C_X = 3'd4,
        REG_C_Y = 3'd5
    } t_reg_idx;

    localparam int unsigned CFG_ADDR_WIDTH = 3;

    // flags that travel with a point through the divider chain
    typedef struct packed {
        logic box;
        logic degen;
        logic neg_b;
        logic neg_c;
        logic sat_b;
        logic sat_c;
    } t_side;

endpackage

// ----- rtl/pitb_point_if.sv -----
// point channel: valid, ready and one query point
// no dependencies
`timescale 1ns / 1ps

interface pitb_point_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

// ----- rtl/pitb_result_if.sv -----
// result channel: valid, ready, three weights and flags
// no dependencies
`timescale 1ns / 1ps

interface pitb_result_if #(
    parameter int WEIGHT_WIDTH = 20
);
    logic                           valid;
    logic                           ready;
    logic signed [WEIGHT_WIDTH-1:0] weight_a;
    logic signed [WEIGHT_WIDTH-1:0] weight_b;
    logic signed [WEIGHT_WIDTH-1:0] weight_c;
    logic                           inside_res;
    logic                           in_box;
    logic                           degenerate;

    modport source (output valid, output weight_a, output weight_b, output weight_c,
                    output inside_res, output in_box, output degenerate, input ready);
    modport sink (input valid, input weight_a, input weight_b, input weight_c,
                  input inside_res, input in_box, input degenerate, output ready);
endinterface

// ----- rtl/pitb_front.sv -----
// front pipeline: differences, bounding-box test, cross products, magnitudes, signs, saturation test
// depends on pitb_pkg
`timescale 1ns / 1ps

module pitb_front import pitb_pkg::*; #(
    parameter int CW = 16,
    parameter int MW = 2 * CW + 2,
    parameter int RW = MW + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_px,
    input  logic signed [CW-1:0] i_py,
    input  logic signed [CW-1:0] i_ax,
    input  logic signed [CW-1:0] i_ay,
    input  logic signed [CW-1:0] i_bx,
    input  logic signed [CW-1:0] i_by,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    output logic                 o_valid,
    output t_side                o_side,
    output logic [MW-1:0]        o_d,
    output logic [RW-1:0]        o_rb,
    output logic [RW-1:0]        o_rc
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic [4:0] r_v;
    logic [4:0] r_box;

    logic signed [DW-1:0] v0x, v0y, v1x, v1y;
    logic signed [CW-1:0] min_x, max_x, min_y, max_y;
    logic                 box;

    logic signed [DW-1:0] r_vpx, r_vpy;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_e0, r_e1;
    logic signed [XW-1:0] r_nb, r_nc, r_den;
    logic [MW-1:0]        r_mb, r_mc, r_md, r_d;
    logic                 r_negb, r_negc, r_degen3, r_degen4;
    logic                 r_negb4, r_negc4, r_satb, r_satc;
    logic [RW-1:0]        r_rb, r_rc;

    always_comb begin
        v0x = $signed({i_bx[CW-1], i_bx}) - $signed({i_ax[CW-1], i_ax});
        v0y = $signed({i_by[CW-1], i_by}) - $signed({i_ay[CW-1], i_ay});
        v1x = $signed({i_cx[CW-1], i_cx}) - $signed({i_ax[CW-1], i_ax});
        v1y = $signed({i_cy[CW-1], i_cy}) - $signed({i_ay[CW-1], i_ay});
        min_x = (i_ax < i_bx) ? i_ax : i_bx;
        min_x = (min_x < i_cx) ? min_x : i_cx;
        max_x = (i_ax > i_bx) ? i_ax : i_bx;
        max_x = (max_x > i_cx) ? max_x : i_cx;
        min_y = (i_ay < i_by) ? i_ay : i_by;
        min_y = (min_y < i_cy) ? min_y : i_cy;
        max_y = (i_ay > i_by) ? i_ay : i_by;
        max_y = (max_y > i_cy) ? max_y : i_cy;
        box = (i_px >= min_x) && (i_px <= max_x) && (i_py >= min_y) && (i_py <= max_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vpx <= $signed({i_px[CW-1], i_px}) - $signed({i_ax[CW-1], i_ax});
            r_vpy <= $signed({i_py[CW-1], i_py}) - $signed({i_ay[CW-1], i_ay});
            r_box <= {r_box[3:0], box};

            r_p0 <= r_vpx * v1y;
            r_p1 <= r_vpy * v1x;
            r_p2 <= v0x * r_vpy;
            r_p3 <= v0y * r_vpx;
            r_e0 <= v0x * v1y;
            r_e1 <= v0y * v1x;

            r_nb  <= $signed({r_p0[PW-1], r_p0}) - $signed({r_p1[PW-1], r_p1});
            r_nc  <= $signed({r_p2[PW-1], r_p2}) - $signed({r_p3[PW-1], r_p3});
            r_den <= $signed({r_e0[PW-1], r_e0}) - $signed({r_e1[PW-1], r_e1});

            r_mb     <= r_nb[XW-1]  ? MW'(-r_nb)  : MW'(r_nb);
            r_mc     <= r_nc[XW-1]  ? MW'(-r_nc)  : MW'(r_nc);
            r_md     <= r_den[XW-1] ? MW'(-r_den) : MW'(r_den);
            r_negb   <= r_nb[XW-1] ^ r_den[XW-1];
            r_negc   <= r_nc[XW-1] ^ r_den[XW-1];
            r_degen3 <= (r_den == '0);

            r_rb     <= {4'b0000, r_mb};
            r_rc     <= {4'b0000, r_mc};
            r_d      <= r_md;
            r_satb   <= ({4'b0000, r_mb} >= {r_md, 4'b0000});
            r_satc   <= ({4'b0000, r_mc} >= {r_md, 4'b0000});
            r_negb4  <= r_negb;
            r_negc4  <= r_negc;
            r_degen4 <= r_degen3;
        end
    end

    assign o_valid      = r_v[4];
    assign o_side.box   = r_box[4];
    assign o_side.degen = r_degen4;
    assign o_side.neg_b = r_negb4;
    assign o_side.neg_c = r_negc4;
    assign o_side.sat_b = r_satb;
    assign o_side.sat_c = r_satc;
    assign o_d          = r_d;
    assign o_rb         = r_rb;
    assign o_rc         = r_rc;
endmodule

// ----- rtl/pitb_div_cell.sv -----
// one restoring division cell: one quotient bit for each of the two weights
// depends on pitb_pkg
`timescale 1ns / 1ps

module pitb_div_cell import pitb_pkg::*; #(
    parameter int MW = 34,
    parameter int RW = MW + 4,
    parameter int QW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_side         i_side,
    input  logic [MW-1:0] i_d,
    input  logic [RW-1:0] i_rb,
    input  logic [RW-1:0] i_rc,
    input  logic [QW-1:0] i_qb,
    input  logic [QW-1:0] i_qc,
    output logic          o_valid,
    output t_side         o_side,
    output logic [MW-1:0] o_d,
    output logic [RW-1:0] o_rb,
    output logic [RW-1:0] o_rc,
    output logic [QW-1:0] o_qb,
    output logic [QW-1:0] o_qc
);
    logic [RW:0]   tb, tc;
    logic [RW-1:0] nb, nc;
    logic          r_valid;
    t_side         r_side;
    logic [MW-1:0] r_d;
    logic [RW-1:0] r_rb, r_rc;
    logic [QW-1:0] r_qb, r_qc;

    // compare against eight times the divisor, then shift the remainder
    always_comb begin
        tb = {1'b0, i_rb} - {2'b00, i_d, 3'b000};
        tc = {1'b0, i_rc} - {2'b00, i_d, 3'b000};
        nb = tb[RW] ? i_rb : tb[RW-1:0];
        nc = tc[RW] ? i_rc : tc[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_d    <= i_d;
            r_rb   <= {nb[RW-2:0], 1'b0};
            r_rc   <= {nc[RW-2:0], 1'b0};
            r_qb   <= {i_qb[QW-2:0], ~tb[RW]};
            r_qc   <= {i_qc[QW-2:0], ~tc[RW]};
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_d     = r_d;
    assign o_rb    = r_rb;
    assign o_rc    = r_rc;
    assign o_qb    = r_qb;
    assign o_qc    = r_qc;
endmodule

// ----- rtl/pitb_finish.sv -----
// rounding, saturation, first weight, inside flag and output skid buffer
// depends on pitb_pkg and pitb_result_if
`timescale 1ns / 1ps

module pitb_finish import pitb_pkg::*; #(
    parameter int F  = 16,
    parameter int WW = F + 4,
    parameter int QW = F + 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_side         i_side,
    input  logic [QW-1:0] i_qb,
    input  logic [QW-1:0] i_qc,
    output logic          o_en,
    pitb_result_if.source o_result
);
    localparam logic signed [WW-1:0] WMAX = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] WMIN = {1'b1, {(WW-1){1'b0}}};
    localparam logic [QW-1:0] LIM = QW'(1) << (F + 3);
    localparam logic signed [WW+1:0] ONE = (WW+2)'(1) << F;
    localparam logic signed [WW+1:0] SMAX = {2'b00, WMAX};
    localparam logic signed [WW+1:0] SMIN = {2'b11, WMIN};

    function automatic logic signed [WW-1:0] f_weight(input logic [QW-1:0] q,
                                                      input logic neg, input logic sat);
        logic [QW:0]   s;
        logic [QW-1:0] r;
        logic [QW-1:0] m;
        s = {1'b0, q} + (QW+1)'(1);
        r = s[QW:1];
        m = ~r + QW'(1);
        if (sat) begin
            return neg ? WMIN : WMAX;
        end else if (neg) begin
            return (r > LIM) ? WMIN : $signed(m[WW-1:0]);
        end else begin
            return (r > QW'(WMAX)) ? WMAX : $signed(r[WW-1:0]);
        end
    endfunction

    logic                 r_v1;
    t_side                r_side1;
    logic signed [WW-1:0] r_wb, r_wc;

    logic signed [WW+1:0] sum;
    logic signed [WW-1:0] wa;
    logic                 in_tri;
    logic                 push;

    logic                 r_ov, r_sv;
    logic signed [WW-1:0] r_o_wa, r_o_wb, r_o_wc, r_s_wa, r_s_wb, r_s_wc;
    logic                 r_o_in, r_o_box, r_o_dg, r_s_in, r_s_box, r_s_dg;

    assign o_en = ~r_sv;
    assign push = o_en & r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_side1 <= i_side;
            r_wb    <= i_side.degen ? '0 : f_weight(i_qb, i_side.neg_b, i_side.sat_b);
            r_wc    <= i_side.degen ? '0 : f_weight(i_qc, i_side.neg_c, i_side.sat_c);
        end
    end

    always_comb begin
        sum = ONE - $signed({{2{r_wb[WW-1]}}, r_wb}) - $signed({{2{r_wc[WW-1]}}, r_wc});
        if (r_side1.degen) begin
            wa = '0;
        end else if (sum > SMAX) begin
            wa = WMAX;
        end else if (sum < SMIN) begin
            wa = WMIN;
        end else begin
            wa = sum[WW-1:0];
        end
        in_tri = !r_side1.degen
              && (wa >= 0) && ($signed({{2{wa[WW-1]}}, wa}) <= ONE)
              && (r_wb >= 0) && ($signed({{2{r_wb[WW-1]}}, r_wb}) <= ONE)
              && (r_wc >= 0) && ($signed({{2{r_wc[WW-1]}}, r_wc}) <= ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_ov && !o_result.ready) begin
            if (push) begin
                r_sv <= 1'b1;
            end
        end else if (r_sv) begin
            r_ov <= 1'b1;
            r_sv <= 1'b0;
        end else begin
            r_ov <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ov && !o_result.ready) begin
            if (push) begin
                r_s_wa  <= wa;
                r_s_wb  <= r_wb;
                r_s_wc  <= r_wc;
                r_s_in  <= in_tri;
                r_s_box <= r_side1.box;
                r_s_dg  <= r_side1.degen;
            end
        end else if (r_sv) begin
            r_o_wa  <= r_s_wa;
            r_o_wb  <= r_s_wb;
            r_o_wc  <= r_s_wc;
            r_o_in  <= r_s_in;
            r_o_box <= r_s_box;
            r_o_dg  <= r_s_dg;
        end else begin
            r_o_wa  <= wa;
            r_o_wb  <= r_wb;
            r_o_wc  <= r_wc;
            r_o_in  <= in_tri;
            r_o_box <= r_side1.box;
            r_o_dg  <= r_side1.degen;
        end
    end

    assign o_result.valid      = r_ov;
    assign o_result.weight_a   = r_o_wa;
    assign o_result.weight_b   = r_o_wb;
    assign o_result.weight_c   = r_o_wc;
    assign o_result.inside_res = r_o_in;
    assign o_result.in_box     = r_o_box;
    assign o_result.degenerate = r_o_dg;
endmodule

// ----- rtl/point_in_triangle_barycentric_core.sv -----
// top level of the barycentric point-in-triangle core
// depends on pitb_pkg, the channel interfaces, pitb_front, pitb_div_cell, pitb_finish
//
// Usage:
//   the triangle is loaded through the write port (i_cfg_we, i_cfg_addr, i_cfg_data),
//   indexes 0..5 are a.x, a.y, b.x, b.y, c.x, c.y; other indexes are ignored.
//   query points enter on i_point, one transaction per point; each gives exactly
//   one result transaction on o_result, in order.
//   throughput: one point per cycle while i_point.ready is high.
//   path from acceptance to o_result.valid: five setup stages, a chain of
//   WEIGHT_FRAC_BITS + 5 divider cells that each settle one quotient bit,
//   one rounding stage and the output register.
//   the divider chain sets the latency; every stage advances only while the
//   skid register is empty.
//   reset clears all vertices to zero and empties the pipeline.
//   when the receiver stalls, a result is held and one more is parked in a
//   skid register; i_point.ready then drops until the skid drains.
//   change the vertices only while the pipeline is empty.
`timescale 1ns / 1ps

module point_in_triangle_barycentric_core import pitb_pkg::*; #(
    parameter int COORD_WIDTH      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [COORD_WIDTH-1:0]    i_cfg_data,
    pitb_point_if.sink                i_point,
    pitb_result_if.source             o_result
);
    localparam int CW = COORD_WIDTH;
    localparam int F  = WEIGHT_FRAC_BITS;
    localparam int MW = 2 * CW + 2;
    localparam int RW = MW + 4;
    localparam int QW = F + 5;
    localparam int WW = F + 4;

    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic                 en;

    logic          c_v    [0:QW];
    t_side         c_side [0:QW];
    logic [MW-1:0] c_d    [0:QW];
    logic [RW-1:0] c_rb   [0:QW];
    logic [RW-1:0] c_rc   [0:QW];
    logic [QW-1:0] c_qb   [0:QW];
    logic [QW-1:0] c_qc   [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_bx <= '0;
            r_by <= '0;
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_A_X: r_ax <= i_cfg_data;
                REG_A_Y: r_ay <= i_cfg_data;
                REG_B_X: r_bx <= i_cfg_data;
                REG_B_Y: r_by <= i_cfg_data;
                REG_C_X: r_cx <= i_cfg_data;
                REG_C_Y: r_cy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_point.ready = en;

    pitb_front #(.CW(CW), .MW(MW), .RW(RW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_point.valid),
        .i_px    (i_point.point_x),
        .i_py    (i_point.point_y),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (r_bx),
        .i_by    (r_by),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_valid (c_v[0]),
        .o_side  (c_side[0]),
        .o_d     (c_d[0]),
        .o_rb    (c_rb[0]),
        .o_rc    (c_rc[0])
    );

    assign c_qb[0] = '0;
    assign c_qc[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        pitb_div_cell #(.MW(MW), .RW(RW), .QW(QW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_v[g]),
            .i_side  (c_side[g]),
            .i_d     (c_d[g]),
            .i_rb    (c_rb[g]),
            .i_rc    (c_rc[g]),
            .i_qb    (c_qb[g]),
            .i_qc    (c_qc[g]),
            .o_valid (c_v[g+1]),
            .o_side  (c_side[g+1]),
            .o_d     (c_d[g+1]),
            .o_rb    (c_rb[g+1]),
            .o_rc    (c_rc[g+1]),
            .o_qb    (c_qb[g+1]),
            .o_qc    (c_qc[g+1])
        );
    end

    pitb_finish #(.F(F), .WW(WW), .QW(QW)) u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_v[QW]),
        .i_side   (c_side[QW]),
        .i_qb     (c_qb[QW]),
        .i_qc     (c_qc[QW]),
        .o_en     (en),
        .o_result (o_result)
    );
endmodule

// ----- rtl/pitb_checker.sv -----
// port-level checks of the point-in-triangle core, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pitb_checker #(
    parameter int F  = 16,
    parameter int WW = F + 4
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic signed [WW-1:0] i_wa,
    input logic signed [WW-1:0] i_wb,
    input logic signed [WW-1:0] i_wc,
    input logic                 i_inside,
    input logic                 i_degen
);
    localparam logic signed [WW+1:0] ONE = (WW+2)'(1) << F;

    logic signed [WW+1:0] wsum;
    logic                 in_range;

    assign wsum = $signed({{2{i_wa[WW-1]}}, i_wa}) + $signed({{2{i_wb[WW-1]}}, i_wb})
                + $signed({{2{i_wc[WW-1]}}, i_wc});
    assign in_range = (i_wa >= 0) && (i_wb >= 0) && (i_wc >= 0)
                   && ($signed({{2{i_wa[WW-1]}}, i_wa}) <= ONE)
                   && ($signed({{2{i_wb[WW-1]}}, i_wb}) <= ONE)
                   && ($signed({{2{i_wc[WW-1]}}, i_wc}) <= ONE);

    `PITB_CHECK_ALWAYS(a_reset_empty, !i_rst_n |=> !i_out_valid, "result valid after reset")
    `PITB_CHECK(a_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_wa)), "stalled result changed")
    `PITB_CHECK(a_degen_zero, (i_out_valid && i_degen) |-> (i_wa == 0 && i_wb == 0 && i_wc == 0 && !i_inside), "degenerate result not cleared")
    `PITB_CHECK(a_inside_sum, (i_out_valid && i_inside) |-> (wsum == ONE && in_range), "inside result with bad weights")
    `PITB_CHECK(a_inside_flag, (i_out_valid && !i_degen && in_range) |-> i_inside, "inside flag missing")
endmodule

bind point_in_triangle_barycentric_core pitb_checker #(
    .F  (WEIGHT_FRAC_BITS),
    .WW (WEIGHT_FRAC_BITS + 4)
) u_pitb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_wa        (o_result.weight_a),
    .i_wb        (o_result.weight_b),
    .i_wc        (o_result.weight_c),
    .i_inside    (o_result.inside_res),
    .i_degen     (o_result.degenerate)
);
